[rtl/nsp_pkg.sv]
//------------------------------------------------------------------------------
// nsp_pkg
// shared types and constants of the nearest segment projection unit
//------------------------------------------------------------------------------
package nsp_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_COORD_BITS   = 32;
    localparam int IDX_W            = 6;
    localparam int CNT_W            = 7;
    localparam int FRAC_W           = 17;
    localparam int T_BITS           = 16;
    localparam logic [FRAC_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [FRAC_W-1:0] EP_DEFAULT = 17'd655;

    localparam logic [0:0] REG_ACTIVE   = 1'b0;
    localparam logic [0:0] REG_ENDPOINT = 1'b1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DIFF, S_MUL, S_SUM, S_CLASS, S_DIV, S_INTERP, S_DIST,
        S_DMUL, S_CMP, S_OUT
    } t_state;

    typedef struct packed {
        logic clear;     // start of a query
        logic read;      // read table entry
        logic diff;
        logic mul;
        logic sum;
        logic classify;
        logic div_step;
        logic interp;
        logic dsub;
        logic dmul;
        logic cmp;
    } t_cmd;

    typedef struct packed {
        logic degenerate;
        logic div_need;
        logic div_done;
    } t_stat;

endpackage

[rtl/nsp_if.sv]
//------------------------------------------------------------------------------
// nsp_if
// valid/ready channel carrying a generic payload
//------------------------------------------------------------------------------
interface nsp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/nsp_ctrl.sv]
//------------------------------------------------------------------------------
// nsp_ctrl
// sequencer stepping a query through all active table entries
//------------------------------------------------------------------------------
module nsp_ctrl
    import nsp_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int SEG_W        = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SEG_W-1:0] i_count,
    input  t_stat            i_stat,
    input  logic             i_out_ready,
    output t_cmd             o_cmd,
    output logic [SEG_W-1:0] o_seg,
    output logic             o_busy,
    output logic             o_out_valid
);

    t_state           r_state, n_state;
    logic [SEG_W-1:0] r_seg, n_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg   <= '0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_seg       = r_seg;
        o_cmd       = '0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.clear = 1'b1;
                    n_seg       = '0;
                    n_state     = (i_count == '0) ? S_OUT : S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_CLASS;
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_stat.degenerate) begin
                    n_seg   = r_seg + 1'b1;
                    n_state = (n_seg == i_count) ? S_OUT : S_READ;
                end else if (!i_stat.div_need || i_stat.div_done) begin
                    n_state = S_INTERP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = S_DIST;
            end
            S_DIST: begin
                o_cmd.dsub = 1'b1;
                n_state    = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.dmul = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_seg     = r_seg + 1'b1;
                n_state   = (n_seg == i_count) ? S_OUT : S_READ;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_seg  = r_seg;
    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/nsp_datapath.sv]
//------------------------------------------------------------------------------
// nsp_datapath
// segment table, projection arithmetic, serial divider and best tracking
//------------------------------------------------------------------------------
module nsp_datapath
    import nsp_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int COORD_BITS   = DEF_COORD_BITS,
    parameter int SEG_W        = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [IDX_W-1:0]             i_load_idx,
    input  logic signed [COORD_BITS-1:0] i_sx,
    input  logic signed [COORD_BITS-1:0] i_sy,
    input  logic signed [COORD_BITS-1:0] i_ex,
    input  logic signed [COORD_BITS-1:0] i_ey,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic [FRAC_W-1:0]            i_ep,
    input  t_cmd                         i_cmd,
    input  logic [SEG_W-1:0]             i_seg,
    output t_stat                        o_stat,
    output logic                         o_found,
    output logic [IDX_W-1:0]             o_best_index,
    output logic [FRAC_W-1:0]            o_t,
    output logic signed [COORD_BITS-1:0] o_qx,
    output logic signed [COORD_BITS-1:0] o_qy,
    output logic                         o_near_start,
    output logic                         o_near_end
);

    localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int DW  = COORD_BITS + 1;   // difference width
    localparam int PW  = 2 * DW;           // product width
    localparam int SW  = PW + 1;           // sum of two products
    localparam int DVW = SW + 1;           // divider remainder
    localparam int TCW = $clog2(T_BITS + 1);
    localparam int MW  = DW + FRAC_W + 1;  // interpolation product

    logic [4*COORD_BITS-1:0] r_mem [MAX_SEGMENTS];
    logic [4*COORD_BITS-1:0] r_rd;

    logic signed [DW-1:0]  r_vx, r_vy, r_wx, r_wy;
    logic signed [COORD_BITS-1:0] r_sx, r_sy;
    logic signed [PW-1:0]  r_vxx, r_vyy, r_wvx, r_wvy;
    logic signed [SW-1:0]  r_v2, r_dot;
    logic [DVW-1:0]        r_rem;
    logic [T_BITS-1:0]     r_q;
    logic [TCW-1:0]        r_cnt;
    logic [FRAC_W-1:0]     r_t;
    logic                  r_div_need;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic signed [DW-1:0]  r_dx, r_dy;
    logic signed [PW-1:0]  r_dxx, r_dyy;

    logic                  r_found;
    logic [IDX_W-1:0]      r_bidx;
    logic [FRAC_W-1:0]     r_bt;
    logic signed [COORD_BITS-1:0] r_bqx, r_bqy;
    logic [SW-1:0]         r_bd2;

    logic [DVW-1:0]        rem_sh;
    logic signed [MW-1:0]  mx, my;
    logic signed [SW-1:0]  d2;

    always_ff @(posedge i_clk) begin
        if (i_load && (32'(i_load_idx) < MAX_SEGMENTS)) begin
            r_mem[i_load_idx[AW-1:0]] <= {i_sx, i_sy, i_ex, i_ey};
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[i_seg[AW-1:0]];
        end
    end

    assign rem_sh = {r_rem[DVW-2:0], 1'b0};

    // floor(t*v/65536) via arithmetic shift
    assign mx = (MW'($signed({1'b0, r_t})) * MW'(r_vx)) >>> T_BITS;
    assign my = (MW'($signed({1'b0, r_t})) * MW'(r_vy)) >>> T_BITS;
    assign d2 = SW'(r_dxx) + SW'(r_dyy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_sx <= r_rd[4*COORD_BITS-1 -: COORD_BITS];
            r_sy <= r_rd[3*COORD_BITS-1 -: COORD_BITS];
            r_vx <= DW'($signed(r_rd[2*COORD_BITS-1 -: COORD_BITS]))
                  - DW'($signed(r_rd[4*COORD_BITS-1 -: COORD_BITS]));
            r_vy <= DW'($signed(r_rd[COORD_BITS-1:0]))
                  - DW'($signed(r_rd[3*COORD_BITS-1 -: COORD_BITS]));
            r_wx <= DW'(i_px) - DW'($signed(r_rd[4*COORD_BITS-1 -: COORD_BITS]));
            r_wy <= DW'(i_py) - DW'($signed(r_rd[3*COORD_BITS-1 -: COORD_BITS]));
        end
        if (i_cmd.mul) begin
            r_vxx <= PW'(r_vx) * PW'(r_vx);
            r_vyy <= PW'(r_vy) * PW'(r_vy);
            r_wvx <= PW'(r_wx) * PW'(r_vx);
            r_wvy <= PW'(r_wy) * PW'(r_vy);
        end
        if (i_cmd.sum) begin
            r_v2  <= SW'(r_vxx) + SW'(r_vyy);
            r_dot <= SW'(r_wvx) + SW'(r_wvy);
            r_cnt <= '0;
            r_q   <= '0;
        end
        if (i_cmd.sum) begin
            r_div_need <= 1'b0;
        end else if (i_cmd.classify) begin
            // first cycle after the sums: classify
            r_div_need <= 1'b1;
            r_rem      <= DVW'(r_dot);
            if (r_dot <= 0)            r_t <= '0;
            else if (r_dot >= r_v2)    r_t <= ONE_Q16;
            else                       r_t <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (rem_sh >= DVW'(r_v2)) begin
                r_rem <= rem_sh - DVW'(r_v2);
                r_q   <= {r_q[T_BITS-2:0], 1'b1};
                if (r_cnt == TCW'(T_BITS - 1)) r_t <= {1'b0, r_q[T_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[T_BITS-2:0], 1'b0};
                if (r_cnt == TCW'(T_BITS - 1)) r_t <= {1'b0, r_q[T_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.interp) begin
            r_qx <= r_sx + COORD_BITS'(mx);
            r_qy <= r_sy + COORD_BITS'(my);
        end
        if (i_cmd.dsub) begin
            r_dx <= DW'(i_px) - DW'(r_qx);
            r_dy <= DW'(i_py) - DW'(r_qy);
        end
        if (i_cmd.dmul) begin
            r_dxx <= PW'(r_dx) * PW'(r_dx);
            r_dyy <= PW'(r_dy) * PW'(r_dy);
        end
    end

    // status: division needed when 0 < dot < v2
    always_comb begin
        o_stat.degenerate = r_div_need && (r_v2 == '0);
        o_stat.div_need   = r_div_need && (r_dot > 0) && (r_dot < r_v2);
        o_stat.div_done   = (r_cnt == TCW'(T_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.clear) begin
            r_found <= 1'b0;
        end else if (i_cmd.cmp && (!r_found || $unsigned(d2) < r_bd2)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_bidx <= '0;
            r_bt   <= '0;
            r_bqx  <= i_px;
            r_bqy  <= i_py;
        end else if (i_cmd.cmp && (!r_found || $unsigned(d2) < r_bd2)) begin
            r_bd2  <= $unsigned(d2);
            r_bidx <= IDX_W'(i_seg);
            r_bt   <= r_t;
            r_bqx  <= r_qx;
            r_bqy  <= r_qy;
        end
    end

    assign o_found      = r_found;
    assign o_best_index = r_bidx;
    assign o_t          = r_bt;
    assign o_qx         = r_bqx;
    assign o_qy         = r_bqy;
    assign o_near_start = r_found && (r_bt <= i_ep);
    assign o_near_end   = r_found && ((18'(r_bt) + 18'(i_ep)) >= 18'(ONE_Q16));

endmodule

[rtl/nearest_segment_projection_unit.sv]
//------------------------------------------------------------------------------
// nearest_segment_projection_unit
// nearest projection of a query point onto a table of 2-D segments
//------------------------------------------------------------------------------
// usage: one input channel carries load and query transactions, one output
// channel carries one result per query. a load writes a table entry and
// gives no result. a query walks entries 0..N-1, N being active_segments
// clamped to MAX_SEGMENTS; each entry passes read, diff, mul, sum, classify,
// div, interp, dist, dmul and cmp, the one shared 16-step restoring divider
// running in div only when the foot falls strictly inside the segment; a
// degenerate entry leaves after div. one query is in work at a time; input
// ready is low from acceptance of a query until the cycle after the result
// is taken. the result stays on the output while the receiver stalls.
// reset clears the sequencer and the config registers (count 0, window 655);
// table entries are undefined until loaded.
// config is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write it only while idle, the block itself does not enforce this.
//------------------------------------------------------------------------------
module nearest_segment_projection_unit
    import nsp_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [FRAC_W-1:0] i_cfg_data,
    nsp_if.sink               in_ch,
    nsp_if.source             out_ch
);

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);

    logic [CNT_W-1:0]  r_active;
    logic [FRAC_W-1:0] r_ep;
    logic [SEG_W-1:0]  count;
    logic              busy, accept, seg_last;
    logic [SEG_W-1:0]  seg;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    t_cmd              cmd;
    t_stat             stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_ep     <= EP_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ACTIVE:   r_active <= i_cfg_data[CNT_W-1:0];
                REG_ENDPOINT: r_ep     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign count = (32'(r_active) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS)
                                                  : SEG_W'(r_active);

    assign in_ch.ready = !busy;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (accept && in_ch.data.action == ACT_QUERY) begin
            r_px <= in_ch.data.point_x;
            r_py <= in_ch.data.point_y;
        end
    end

    nsp_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .SEG_W(SEG_W)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && in_ch.data.action == ACT_QUERY),
        .i_count    (count),
        .i_stat     (stat),
        .i_out_ready(out_ch.ready),
        .o_cmd      (cmd),
        .o_seg      (seg),
        .o_busy     (busy),
        .o_out_valid(out_ch.valid)
    );

    nsp_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS), .SEG_W(SEG_W))
    u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && in_ch.data.action == ACT_LOAD),
        .i_load_idx  (in_ch.data.seg_index),
        .i_sx        (in_ch.data.start_x),
        .i_sy        (in_ch.data.start_y),
        .i_ex        (in_ch.data.end_x),
        .i_ey        (in_ch.data.end_y),
        .i_px        (cmd.clear ? in_ch.data.point_x : r_px),
        .i_py        (cmd.clear ? in_ch.data.point_y : r_py),
        .i_ep        (r_ep),
        .i_cmd       (cmd),
        .i_seg       (seg),
        .o_stat      (stat),
        .o_found     (out_ch.data.found),
        .o_best_index(out_ch.data.best_index),
        .o_t         (out_ch.data.t_fraction),
        .o_qx        (out_ch.data.proj_x),
        .o_qy        (out_ch.data.proj_y),
        .o_near_start(out_ch.data.near_start),
        .o_near_end  (out_ch.data.near_end)
    );

    assign seg_last = (seg == count);

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !in_ch.ready) else $error("input taken while busy");
    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !out_ch.valid) |-> (seg < count || seg_last))
        else $error("segment counter beyond count");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped under stall");

endmodule

[bench/tb_types_pkg.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_types_pkg
// transaction layouts of the segment projection channels
//------------------------------------------------------------------------------
package tb_types_pkg;

    typedef struct packed {
        logic               action;
        logic [5:0]         seg_index;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [5:0]         best_index;
        logic [16:0]        t_fraction;
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic               near_start;
        logic               near_end;
    } t_out_item;

endpackage

[bench/nsp_checker.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// nsp_checker
// watches both channels and the config port, keeps a shadow segment table,
// predicts every query result and compares it field by field in order
//------------------------------------------------------------------------------
module nsp_checker
    import nsp_pkg::*;
    import tb_types_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    nsp_if              in_ch,
    nsp_if              out_ch,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_found_count
);

    t_in_item    seg_tab [64];
    logic [6:0]  active_cnt;
    logic [16:0] ep_frac;
    t_out_item   expected_results[$];

    function automatic t_out_item project_point(logic signed [31:0] px,
                                                logic signed [31:0] py);
        t_out_item r;
        logic signed [127:0] vx, vy, wx, wy, v2, dot, tt, qx, qy, dx, dy, d2, bd2;
        logic [16:0] t;
        int n;
        r = '0;
        r.proj_x = px;
        r.proj_y = py;
        bd2 = '0;
        n = (active_cnt > 64) ? 64 : active_cnt;
        for (int i = 0; i < n; i++) begin
            vx = seg_tab[i].end_x;
            vx = vx - seg_tab[i].start_x;
            vy = seg_tab[i].end_y;
            vy = vy - seg_tab[i].start_y;
            v2 = vx * vx + vy * vy;
            if (v2 != 0) begin
                wx = px;
                wx = wx - seg_tab[i].start_x;
                wy = py;
                wy = wy - seg_tab[i].start_y;
                dot = wx * vx + wy * vy;
                if (dot <= 0) t = '0;
                else if (dot >= v2) t = ONE_Q16;
                else t = 17'((dot <<< 16) / v2);
                tt = {111'd0, t};
                qx = seg_tab[i].start_x;
                qx = qx + ((tt * vx) >>> 16);
                qy = seg_tab[i].start_y;
                qy = qy + ((tt * vy) >>> 16);
                dx = px;
                dx = dx - qx;
                dy = py;
                dy = dy - qy;
                d2 = dx * dx + dy * dy;
                if (!r.found || d2 < bd2) begin
                    r.found = 1'b1;
                    bd2 = d2;
                    r.best_index = 6'(i);
                    r.t_fraction = t;
                    r.proj_x = qx[31:0];
                    r.proj_y = qy[31:0];
                end
            end
        end
        if (r.found) begin
            r.near_start = (r.t_fraction <= ep_frac);
            r.near_end   = (int'(r.t_fraction) + int'(ep_frac) >= 65536);
        end
        return r;
    endfunction

    function automatic int field_diff(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e, g;
        int bad;
        if (!i_rst_n) begin
            active_cnt = '0;
            ep_frac = EP_DEFAULT;
            expected_results.delete();
            o_fail_count = 0;
            o_found_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ACTIVE) active_cnt = i_cfg_data[6:0];
                else ep_frac = i_cfg_data;
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.data.action == ACT_LOAD) seg_tab[in_ch.data.seg_index] = in_ch.data;
                else expected_results = {expected_results,
                                         project_point(in_ch.data.point_x,
                                                       in_ch.data.point_y)};
            end
            if (out_ch.valid && out_ch.ready) begin
                g = out_ch.data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction %0h", $realtime, g);
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    bad = field_diff("found", e.found, g.found)
                        + field_diff("best_index", e.best_index, g.best_index)
                        + field_diff("t_fraction", e.t_fraction, g.t_fraction)
                        + field_diff("proj_x", e.proj_x, g.proj_x)
                        + field_diff("proj_y", e.proj_y, g.proj_y)
                        + field_diff("near_start", e.near_start, g.near_start)
                        + field_diff("near_end", e.near_end, g.near_end);
                    if (bad != 0) o_fail_count++;
                    if (g.found) o_found_count++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// drives loads and queries with random gaps and back pressure through several
// config settings; the checker predicts and compares every query result
//------------------------------------------------------------------------------
module tb_top;
    import nsp_pkg::*;
    import tb_types_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [16:0] i_cfg_data;
    int          fail_count, pending, found_count;
    int          loads_sent, queries_sent, results_taken, idle_cycles;
    bit          loaded [64];
    t_in_item    shadow [64];
    bit          no_gaps;
    bit          pressure_done;

    nsp_if #(.T(t_in_item))  in_ch ();
    nsp_if #(.T(t_out_item)) out_ch ();

    nearest_segment_projection_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    nsp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch), .out_ch(out_ch), .o_fail_count(fail_count),
        .o_pending(pending), .o_found_count(found_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2097151)) - 1048576;
            2: case ($urandom_range(0, 3))
                   0: return CMIN;
                   1: return CMAX;
                   2: return 0;
                   default: return -1;
               endcase
            default: return ($signed($urandom_range(0, 200)) - 100) * 65536;
        endcase
    endfunction

    function automatic int prefix_len();
        int n;
        n = 0;
        while (n < 64 && loaded[n]) n++;
        return n;
    endfunction

    // random transaction generators
    function automatic t_in_item make_load(int idx);
        t_in_item it;
        it = '0;
        it.action = ACT_LOAD;
        it.seg_index = 6'(idx);
        it.start_x = rand_coord();
        it.start_y = rand_coord();
        case ($urandom_range(0, 5))
            0, 1: begin
                it.end_x = rand_coord();
                it.end_y = rand_coord();
            end
            2: begin
                it.end_x = it.start_x;
                it.end_y = it.start_y;
            end
            3: begin
                it.end_x = it.start_x + ($signed($urandom_range(0, 65535)) - 32768);
                it.end_y = it.start_y;
            end
            default: begin
                it.end_x = it.start_x + ($signed($urandom_range(0, 8388607)) - 4194304);
                it.end_y = it.start_y + ($signed($urandom_range(0, 8388607)) - 4194304);
            end
        endcase
        it.point_x = $urandom;
        it.point_y = $urandom;
        return it;
    endfunction

    function automatic t_in_item make_query();
        t_in_item it;
        int s;
        it = '0;
        it.action = ACT_QUERY;
        it.seg_index = $urandom;
        it.start_x = $urandom;
        it.start_y = $urandom;
        it.end_x = $urandom;
        it.end_y = $urandom;
        s = $urandom_range(0, 63);
        if ($urandom_range(0, 2) != 0 && loaded[s]) begin
            it.point_x = shadow[s].start_x + ($signed($urandom_range(0, 4194303)) - 2097152);
            it.point_y = shadow[s].end_y + ($signed($urandom_range(0, 4194303)) - 2097152);
        end else begin
            it.point_x = rand_coord();
            it.point_y = rand_coord();
        end
        return it;
    endfunction

    task automatic send(input t_in_item it);
        int g;
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (it.action == ACT_LOAD) begin
            loaded[it.seg_index] = 1'b1;
            shadow[it.seg_index] = it;
            loads_sent++;
        end else begin
            queries_sent++;
        end
        g = pick_gap();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic load_seg(int idx, logic signed [31:0] sx, logic signed [31:0] sy,
                            logic signed [31:0] ex, logic signed [31:0] ey);
        t_in_item it;
        it = '0;
        it.action = ACT_LOAD;
        it.seg_index = 6'(idx);
        it.start_x = sx;
        it.start_y = sy;
        it.end_x = ex;
        it.end_y = ey;
        send(it);
    endtask

    task automatic query_at(logic signed [31:0] px, logic signed [31:0] py);
        t_in_item it;
        it = '0;
        it.action = ACT_QUERY;
        it.point_x = px;
        it.point_y = py;
        send(it);
    endtask

    // config is only touched once every query result has come back
    task automatic configure(logic [6:0] cnt, logic [16:0] ep);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_ACTIVE;
        i_cfg_data <= {10'd0, cnt};
        @(posedge i_clk);
        i_cfg_index <= REG_ENDPOINT;
        i_cfg_data <= ep;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(logic [6:0] cnt, logic [16:0] ep, int items);
        configure(cnt, ep);
        for (int k = 0; k < items; k++) begin
            no_gaps = (k >= items / 2) && (k < items / 2 + 10);
            if ($urandom_range(0, 99) < 35) send(make_load($urandom_range(0, 63)));
            else send(make_query());
        end
        no_gaps = 1'b0;
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial begin
        int gap;
        gap = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (out_ch.valid && out_ch.ready) begin
                results_taken++;
                if (results_taken == 15 && !pressure_done) begin
                    pressure_done = 1'b1;
                    gap = 3000;
                end else begin
                    gap = pick_gap();
                end
            end else if (gap > 0) begin
                gap--;
            end
            out_ch.ready <= (gap == 0);
            @(posedge i_clk);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_ACTIVE;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        loads_sent = 0;
        queries_sent = 0;
        results_taken = 0;
        no_gaps = 1'b0;
        pressure_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, then special shapes
        query_at(CMAX, CMIN);
        load_seg(0, 5, 5, 5, 5);
        load_seg(1, CMIN, CMIN, CMAX, CMAX);
        load_seg(2, 0, 0, 10 * 65536, 0);
        load_seg(3, -65536, 0, -65536, -20 * 65536);
        load_seg(4, CMAX, CMIN, CMIN, CMAX);
        load_seg(5, 0, 0, 1, 0);
        load_seg(6, 0, 0, 10 * 65536, 0);
        load_seg(7, -100, -100, -300, 200);
        configure(1, 655);
        query_at(123, -456);
        configure(8, 655);
        query_at(5 * 65536, 3 * 65536);
        query_at(-3 * 65536, 1);
        query_at(40 * 65536, -2);
        query_at(CMIN, CMIN);
        query_at(CMAX, CMAX);
        query_at(-65536, -10 * 65536);
        query_at(-200, 50);
        configure(8, 17'd65536);
        query_at(65536, 65536);
        configure(8, 17'h1FFFF);
        query_at(7 * 65536, -65536);
        configure(8, 0);
        query_at(0, 1);

        // random phases, table filled before the saturated count
        random_phase(0, 0, 15);
        random_phase(7'(prefix_len()), 17'd65536, 35);
        for (int i = 0; i < 64; i++)
            if (!loaded[i]) send(make_load(i));
        random_phase(64, 17'($urandom_range(0, 131071)), 40);
        random_phase(7'd127, 17'h1FFFF, 30);
        random_phase(7'($urandom_range(1, 64)), 17'($urandom_range(0, 8000)), 40);
        random_phase(7'd100, 655, 25);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d loads and %0d queries, %0d results with a segment found",
                 loads_sent, queries_sent, found_count);
        $display("segment counts 0 to 127 and endpoint windows 0 to 131071 exercised");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
